### design/lmds_pkg.sv
package lmds_pkg;

    localparam int MATRIX_ROWS    = 6;
    localparam int LED_COLS       = 6;
    localparam int ROW_W          = 3;
    localparam int DIGIT_W        = 4;
    localparam int CODE_W         = 5;
    localparam int BYTES_PER_TICK = 6;
    localparam int BYTE_IDX_W     = 3;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [2:0] OP_SET_LED   = 3'd0;
    localparam logic [2:0] OP_FILL_LEDS = 3'd1;
    localparam logic [2:0] OP_WR_DIGIT  = 3'd2;
    localparam logic [2:0] OP_REFRESH   = 3'd3;
    localparam logic [2:0] OP_BUTTON    = 3'd4;

    localparam logic KIND_SHIFT  = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    localparam logic [CODE_W-1:0] BLANK_CODE = 5'd16;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [2:0]         led_column;
        logic [ROW_W-1:0]   led_row;
        logic               led_on;
        logic [DIGIT_W-1:0] digit_index;
        logic [CODE_W-1:0]  digit_value;
        logic [7:0]         pin_levels;
    } lmds_in_t;

    typedef struct packed {
        logic             result_kind;
        logic [7:0]       data_byte;
        logic [ROW_W-1:0] row_index;
        logic             last;
    } lmds_out_t;

    typedef struct packed {
        logic                kind;
        logic [ROW_W-1:0]    row;
        logic [LED_COLS-1:0] row_bits;
        logic [DIGIT_W-1:0]  digit;
        logic [CODE_W-1:0]   code;
        logic [7:0]          mask;
    } lmds_job_t;

    function automatic logic [7:0] seg_code(input logic [CODE_W-1:0] code);
        logic [7:0] seg;
        unique case (code)
            5'd0:    seg = 8'h3F;
            5'd1:    seg = 8'h06;
            5'd2:    seg = 8'h5B;
            5'd3:    seg = 8'h4F;
            5'd4:    seg = 8'h66;
            5'd5:    seg = 8'h6D;
            5'd6:    seg = 8'h7D;
            5'd7:    seg = 8'h07;
            5'd8:    seg = 8'h7F;
            5'd9:    seg = 8'h67;
            5'd10:   seg = 8'h77;
            5'd11:   seg = 8'h7C;
            5'd12:   seg = 8'h39;
            5'd13:   seg = 8'h5E;
            5'd14:   seg = 8'h79;
            5'd15:   seg = 8'h71;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

### design/lmds_front.sv
module lmds_front
    import lmds_pkg::*;
#(
    parameter int DIGIT_COUNT = 9
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lmds_in_t  s_payload,
    output logic      job_valid,
    input  logic      job_ready,
    output lmds_job_t job
);

    localparam int DIGIT_IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    logic [LED_COLS-1:0] led_bits_reg    [MATRIX_ROWS];
    logic [CODE_W-1:0]   digit_store_reg [DIGIT_COUNT];
    logic [ROW_W-1:0]    row_counter_reg;
    logic [ROW_W-1:0]    row_counter_next;
    logic [DIGIT_W-1:0]  digit_counter_reg;
    logic [DIGIT_W-1:0]  digit_counter_next;
    logic                accept;
    logic                do_tick;
    logic                do_set;
    logic                do_digit;
    logic [CODE_W-1:0]   digit_clamped;

    assign s_ready  = job_ready;
    assign accept   = s_valid && s_ready;
    assign do_tick  = accept && (s_payload.opcode == OP_REFRESH);
    assign do_set   = accept && (s_payload.opcode == OP_SET_LED)
                      && (s_payload.led_column < 3'(LED_COLS))
                      && (s_payload.led_row < ROW_W'(MATRIX_ROWS));
    assign do_digit = accept && (s_payload.opcode == OP_WR_DIGIT)
                      && (s_payload.digit_index < DIGIT_W'(DIGIT_COUNT));
    assign digit_clamped = (s_payload.digit_value > BLANK_CODE) ? BLANK_CODE
                                                                : s_payload.digit_value;

    assign job_valid = s_valid && ((s_payload.opcode == OP_REFRESH)
                                   || (s_payload.opcode == OP_BUTTON));

    always_comb begin
        job.kind     = (s_payload.opcode == OP_BUTTON) ? KIND_BUTTON : KIND_SHIFT;
        job.row      = row_counter_reg;
        job.row_bits = led_bits_reg[row_counter_reg];
        job.digit    = digit_counter_reg;
        job.code     = digit_store_reg[digit_counter_reg[DIGIT_IW-1:0]];
        job.mask     = ~s_payload.pin_levels;
    end

    assign row_counter_next = (row_counter_reg == ROW_W'(MATRIX_ROWS - 1)) ? '0
                              : row_counter_reg + 1'b1;
    assign digit_counter_next = (digit_counter_reg == DIGIT_W'(DIGIT_COUNT - 1)) ? '0
                                : digit_counter_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_counter_reg   <= '0;
            digit_counter_reg <= '0;
            for (int i = 0; i < MATRIX_ROWS; i++) begin
                led_bits_reg[i] <= '0;
            end
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                digit_store_reg[i] <= CODE_W'(i);
            end
        end else begin
            if (do_tick) begin
                row_counter_reg   <= row_counter_next;
                digit_counter_reg <= digit_counter_next;
            end
            for (int i = 0; i < MATRIX_ROWS; i++) begin
                for (int j = 0; j < LED_COLS; j++) begin
                    if (accept && (s_payload.opcode == OP_FILL_LEDS)) begin
                        led_bits_reg[i][j] <= s_payload.led_on;
                    end else if (do_set && (s_payload.led_row == ROW_W'(i))
                                 && (s_payload.led_column == 3'(j))) begin
                        led_bits_reg[i][j] <= s_payload.led_on;
                    end
                end
            end
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                if (do_digit && (s_payload.digit_index == DIGIT_W'(i))) begin
                    digit_store_reg[i] <= digit_clamped;
                end
            end
        end
    end

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_counter_reg < ROW_W'(MATRIX_ROWS))
        else $error("row counter out of range");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_counter_reg < DIGIT_W'(DIGIT_COUNT))
        else $error("digit counter out of range");

    a_tick_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        do_tick |=> row_counter_reg == $past(row_counter_next))
        else $error("row counter did not advance on refresh");

endmodule

### design/lmds_queue.sv
module lmds_queue
    import lmds_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  lmds_job_t push_job,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output lmds_job_t head_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lmds_job_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

### design/lmds_back.sv
module lmds_back
    import lmds_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      head_valid,
    input  lmds_job_t head_job,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output lmds_out_t m_payload
);

    logic [BYTE_IDX_W-1:0] idx_reg;
    logic                  m_valid_reg;
    lmds_out_t             m_payload_reg;
    logic                  load;
    logic                  low_half;
    logic [7:0]            row_sel;
    logic [7:0]            lo_bits;
    logic [7:0]            hi_bits;
    logic [7:0]            tick_byte;
    logic                  tick_last;
    lmds_out_t             next_out;

    assign load      = head_valid && (!m_valid_reg || m_ready);
    assign tick_last = (idx_reg == BYTE_IDX_W'(BYTES_PER_TICK - 1));
    assign pop       = load && ((head_job.kind == KIND_BUTTON) || tick_last);

    assign low_half = (head_job.row < 3'd3);
    assign row_sel  = low_half ? (8'd1 << head_job.row) : (8'd1 << (head_job.row - 3'd3));
    assign lo_bits  = {1'b0, head_job.row_bits[2:0], 4'b0000};
    assign hi_bits  = {1'b0, head_job.row_bits[5:3], 4'b0000};

    always_comb begin
        unique case (idx_reg)
            3'd0:    tick_byte = low_half ? 8'h00 : (row_sel | lo_bits);
            3'd1:    tick_byte = low_half ? 8'h00 : (row_sel | hi_bits);
            3'd2:    tick_byte = low_half ? (row_sel | hi_bits) : 8'h00;
            3'd3:    tick_byte = low_half ? (row_sel | lo_bits) : 8'h00;
            3'd4:    tick_byte = (head_job.digit == '0) ? 8'h00
                                 : (8'd1 << (head_job.digit - 1'b1));
            default: tick_byte = seg_code(head_job.code)
                                 | {(head_job.digit == '0), 7'b0000000};
        endcase
    end

    always_comb begin
        if (head_job.kind == KIND_BUTTON) begin
            next_out.result_kind = KIND_BUTTON;
            next_out.data_byte   = head_job.mask;
            next_out.row_index   = head_job.row;
            next_out.last        = 1'b1;
        end else begin
            next_out.result_kind = KIND_SHIFT;
            next_out.data_byte   = tick_byte;
            next_out.row_index   = '0;
            next_out.last        = tick_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_payload_reg <= next_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pop) begin
                idx_reg <= '0;
            end else if (load) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg < BYTE_IDX_W'(BYTES_PER_TICK))
        else $error("byte index out of range");

    a_job_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != '0) |-> (head_valid && (head_job.kind == KIND_SHIFT)))
        else $error("refresh request lost mid-sequence");

    a_button_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_payload.result_kind == KIND_BUTTON))
        |-> (m_payload.last && (m_payload.row_index < ROW_W'(MATRIX_ROWS))))
        else $error("bad button result");

endmodule

### design/led_matrix_and_digit_scanner.sv
// LED matrix and seven-segment scanner. The front takes one request per cycle while its
// two-entry job queue has room: LED and digit writes update the display state at once and
// produce nothing, a refresh tick or button sample snapshots the current row, digit and
// inverted pin byte into the queue. The back drains the queue through a registered
// output, one result per cycle while the output is accepted: a refresh tick gives six
// shift bytes, the last flagged, and a button sample gives one result. The byte sequencer
// starts the next queued job only after a tick's last byte; no clearing pass after reset.
module led_matrix_and_digit_scanner
    import lmds_pkg::*;
#(
    parameter int DIGIT_COUNT = 9
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lmds_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output lmds_out_t m_payload
);

    logic      job_valid;
    logic      queue_full;
    lmds_job_t job;
    logic      pop;
    logic      head_valid;
    lmds_job_t head_job;

    lmds_front #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .job_valid (job_valid),
        .job_ready (!queue_full),
        .job       (job)
    );

    lmds_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_valid && s_ready),
        .push_job   (job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    lmds_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule
